// File: rtl/dmsbt_pkg.sv
// ----------------------------------------------------------------------------
// dmsbt_pkg
// Shared types, codes and field widths of the device mode sequencer with
// breath guide timer.
// ----------------------------------------------------------------------------
package dmsbt_pkg;

    localparam int OP_W      = 4;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int CYC_W     = MS_W + 1;
    localparam int SRC_W     = 4;
    localparam int CODE_W    = 16;
    localparam int MODE_W    = 4;
    localparam int LINK_W    = 2;
    localparam int LED_W     = 3;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = $clog2(TIME_W);

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 120;
    localparam int CFG_IDX_W = 1;

    localparam logic [MS_W-1:0]   INHALE_RESET = 16'd4000;
    localparam logic [MS_W-1:0]   EXHALE_RESET = 16'd5000;
    localparam logic [CFG_IDX_W-1:0] CFG_INHALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXHALE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY     = 4'd0,
        OP_BEGIN     = 4'd1,
        OP_TICK      = 4'd2,
        OP_LINK_UP   = 4'd3,
        OP_LINK_DOWN = 4'd4,
        OP_CAL_START = 4'd5,
        OP_CAL_DONE  = 4'd6,
        OP_CAL_FAIL  = 4'd7,
        OP_PRESS_OK  = 4'd8,
        OP_COUNTDOWN = 4'd9,
        OP_TEST_DONE = 4'd10,
        OP_GUIDE_REQ = 4'd11,
        OP_GUIDE_END = 4'd12,
        OP_ERROR     = 4'd13
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_BOOT      = 4'd0,
        MODE_ADV       = 4'd1,
        MODE_WAIT_CAL  = 4'd2,
        MODE_CAL       = 4'd3,
        MODE_MONITOR   = 4'd4,
        MODE_PRESS     = 4'd5,
        MODE_COUNTDOWN = 4'd6,
        MODE_ACTIVE    = 4'd7,
        MODE_GUIDE     = 4'd8,
        MODE_ERROR     = 4'd9
    } mode_t;

    typedef enum logic [LINK_W-1:0] {
        LINK_IDLE      = 2'd0,
        LINK_ADV       = 2'd1,
        LINK_CONNECTED = 2'd2,
        LINK_DISCONN   = 2'd3
    } link_t;

    typedef enum logic [KIND_W-1:0] {
        PHASE_IDLE   = 2'd0,
        PHASE_INHALE = 2'd1,
        PHASE_EXHALE = 2'd2
    } phase_t;

    function automatic logic [LED_W-1:0] led_of_mode(input logic [MODE_W-1:0] m);
        logic [LED_W-1:0] led;
        case (m)
            MODE_BOOT:      led = 3'd0;
            MODE_ADV:       led = 3'd1;
            MODE_WAIT_CAL:  led = 3'd2;
            MODE_CAL:       led = 3'd3;
            MODE_MONITOR:   led = 3'd4;
            MODE_PRESS:     led = 3'd5;
            MODE_COUNTDOWN: led = 3'd5;
            MODE_ACTIVE:    led = 3'd6;
            MODE_GUIDE:     led = 3'd3;
            MODE_ERROR:     led = 3'd7;
            default:        led = 3'd0;
        endcase
        return led;
    endfunction

endpackage

// File: rtl/device_mode_sequencer_breath_timer_core.sv
// ----------------------------------------------------------------------------
// device_mode_sequencer_breath_timer_core
// Mode sequencer of a wearable device with a breath guide phase timer.
//
//   channel   dir  ports                         transaction
//   s_        in   s_tvalid/s_tready/s_tdata/    one timestamped event
//                  s_tuser
//   m_        out  m_tvalid/m_tready/m_tdata     one status snapshot
//   cfg_      in   cfg_wr_en/cfg_index/cfg_wdata phase length write
//
// Outside a running guide an event goes from setup straight to the result;
// during one, the 32 steps of the serial restoring modulo unit lie between
// setup and the phase step, and with both phase lengths zero they are skipped.
// s_tready is high only while the sequencer is idle; a snapshot waits in
// the output register until m_tready takes it.
// aresetn is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module device_mode_sequencer_breath_timer_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_ms[31:0], keep_pressed[32], guide_duration_ms[64:33],
    // error_source[68:65], error_code[84:69], error_recoverable[85]
    input  logic [dmsbt_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[3:0]
    input  logic [dmsbt_pkg::OP_W-1:0]          s_tuser,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mode[3:0], link[5:4], led_mode[8:6], session_number[40:9],
    // phase_kind[42:41], phase_elapsed_ms[58:43], phase_length_ms[74:59],
    // phase_left_ms[90:75], error_active[91], last_error_source[95:92],
    // last_error_code[111:96], last_error_recoverable[112]
    output logic [dmsbt_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                                cfg_wr_en,
    input  logic [dmsbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmsbt_pkg::MS_W-1:0]          cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_PHASE  = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [dmsbt_pkg::MS_W-1:0]   inhale_reg, exhale_reg;

    logic [dmsbt_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [dmsbt_pkg::LINK_W-1:0] link_reg, link_next;
    logic [dmsbt_pkg::TIME_W-1:0] session_reg, session_next;
    logic [dmsbt_pkg::TIME_W-1:0] gstart_reg, gstart_next;
    logic [dmsbt_pkg::TIME_W-1:0] gend_reg, gend_next;
    logic                         err_flag_reg, err_flag_next;
    logic [dmsbt_pkg::SRC_W-1:0]  err_src_reg, err_src_next;
    logic [dmsbt_pkg::CODE_W-1:0] err_code_reg, err_code_next;
    logic                         err_rec_reg, err_rec_next;

    logic [dmsbt_pkg::TIME_W-1:0] now_reg;
    logic [dmsbt_pkg::TIME_W-1:0] dvd_reg;
    logic [dmsbt_pkg::CYC_W-1:0]  rem_reg;
    logic [dmsbt_pkg::CNT_W-1:0]  cnt_reg;

    logic [dmsbt_pkg::KIND_W-1:0] kind_reg;
    logic [dmsbt_pkg::MS_W-1:0]   el_reg, len_reg, left_reg;

    logic                         s_fire, m_fire;
    dmsbt_pkg::op_t               op;
    logic [dmsbt_pkg::TIME_W-1:0] in_now, in_dur;

    logic [dmsbt_pkg::CYC_W-1:0]  cycle_len;
    logic [dmsbt_pkg::CYC_W:0]    trial;
    logic [dmsbt_pkg::CYC_W:0]    trial_diff;
    logic                         guide_on;
    logic                         in_inhale;
    logic [dmsbt_pkg::CYC_W-1:0]  ex_off;
    logic [dmsbt_pkg::MS_W-1:0]   el_sel, len_sel;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_RESULT);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    assign op     = dmsbt_pkg::op_t'(s_tuser);
    assign in_now = s_tdata[31:0];
    assign in_dur = s_tdata[64:33];

    assign cycle_len  = {1'b0, inhale_reg} + {1'b0, exhale_reg};
    assign trial      = {rem_reg, dvd_reg[dmsbt_pkg::TIME_W-1]};
    assign trial_diff = trial - {1'b0, cycle_len};
    assign guide_on   = (mode_reg == dmsbt_pkg::MODE_GUIDE) && (gstart_reg != '0);

    assign in_inhale = (rem_reg < {1'b0, inhale_reg});
    assign ex_off    = rem_reg - {1'b0, inhale_reg};
    assign el_sel    = in_inhale ? rem_reg[dmsbt_pkg::MS_W-1:0]
                                 : ex_off[dmsbt_pkg::MS_W-1:0];
    assign len_sel   = in_inhale ? inhale_reg : exhale_reg;

    // Event decode
    always_comb begin
        mode_next     = mode_reg;
        link_next     = link_reg;
        session_next  = session_reg;
        gstart_next   = gstart_reg;
        gend_next     = gend_reg;
        err_flag_next = err_flag_reg;
        err_src_next  = err_src_reg;
        err_code_next = err_code_reg;
        err_rec_next  = err_rec_reg;
        unique case (op)
            dmsbt_pkg::OP_BEGIN: begin
                session_next  = 32'd1;
                link_next     = dmsbt_pkg::LINK_ADV;
                err_flag_next = 1'b0;
                err_src_next  = '0;
                err_code_next = '0;
                err_rec_next  = 1'b0;
                mode_next     = dmsbt_pkg::MODE_ADV;
            end
            dmsbt_pkg::OP_TICK: begin
                if (mode_reg == dmsbt_pkg::MODE_GUIDE && gend_reg != '0
                    && in_now >= gend_reg) begin
                    gstart_next = '0;
                    gend_next   = '0;
                    mode_next   = dmsbt_pkg::MODE_MONITOR;
                end
            end
            dmsbt_pkg::OP_LINK_UP: begin
                link_next    = dmsbt_pkg::LINK_CONNECTED;
                session_next = session_reg + 32'd1;
                mode_next    = dmsbt_pkg::MODE_WAIT_CAL;
            end
            dmsbt_pkg::OP_LINK_DOWN: begin
                link_next = dmsbt_pkg::LINK_DISCONN;
                mode_next = dmsbt_pkg::MODE_ADV;
            end
            dmsbt_pkg::OP_CAL_START: mode_next = dmsbt_pkg::MODE_CAL;
            dmsbt_pkg::OP_CAL_DONE:  mode_next = dmsbt_pkg::MODE_MONITOR;
            dmsbt_pkg::OP_CAL_FAIL:  mode_next = dmsbt_pkg::MODE_WAIT_CAL;
            dmsbt_pkg::OP_PRESS_OK:  mode_next = dmsbt_pkg::MODE_COUNTDOWN;
            dmsbt_pkg::OP_COUNTDOWN: begin
                mode_next = s_tdata[32] ? dmsbt_pkg::MODE_ACTIVE : dmsbt_pkg::MODE_CAL;
            end
            dmsbt_pkg::OP_TEST_DONE: mode_next = dmsbt_pkg::MODE_MONITOR;
            dmsbt_pkg::OP_GUIDE_REQ: begin
                gstart_next = in_now;
                gend_next   = in_now + in_dur;
                mode_next   = dmsbt_pkg::MODE_GUIDE;
            end
            dmsbt_pkg::OP_GUIDE_END: begin
                gstart_next = '0;
                gend_next   = '0;
                mode_next   = dmsbt_pkg::MODE_MONITOR;
            end
            dmsbt_pkg::OP_ERROR: begin
                err_flag_next = 1'b1;
                err_src_next  = s_tdata[68:65];
                err_code_next = s_tdata[84:69];
                err_rec_next  = s_tdata[85];
                mode_next     = dmsbt_pkg::MODE_ERROR;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_SETUP;
            ST_SETUP: begin
                if (!guide_on)
                    state_next = ST_RESULT;
                else if (cycle_len == '0)
                    state_next = ST_PHASE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:    if (cnt_reg == '0) state_next = ST_PHASE;
            ST_PHASE:  state_next = ST_RESULT;
            ST_RESULT: if (m_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            inhale_reg   <= dmsbt_pkg::INHALE_RESET;
            exhale_reg   <= dmsbt_pkg::EXHALE_RESET;
            mode_reg     <= dmsbt_pkg::MODE_BOOT;
            link_reg     <= dmsbt_pkg::LINK_IDLE;
            session_reg  <= 32'd1;
            gstart_reg   <= '0;
            gend_reg     <= '0;
            err_flag_reg <= 1'b0;
            err_src_reg  <= '0;
            err_code_reg <= '0;
            err_rec_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    dmsbt_pkg::CFG_INHALE: inhale_reg <= cfg_wdata;
                    dmsbt_pkg::CFG_EXHALE: exhale_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_fire) begin
                mode_reg     <= mode_next;
                link_reg     <= link_next;
                session_reg  <= session_next;
                gstart_reg   <= gstart_next;
                gend_reg     <= gend_next;
                err_flag_reg <= err_flag_next;
                err_src_reg  <= err_src_next;
                err_code_reg <= err_code_next;
                err_rec_reg  <= err_rec_next;
            end
        end
    end

    // Serial modulo and phase datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) now_reg <= in_now;
            end
            ST_SETUP: begin
                dvd_reg  <= now_reg - gstart_reg;
                rem_reg  <= '0;
                cnt_reg  <= dmsbt_pkg::CNT_W'(dmsbt_pkg::TIME_W - 1);
                kind_reg <= dmsbt_pkg::PHASE_IDLE;
                el_reg   <= '0;
                len_reg  <= '0;
                left_reg <= '0;
            end
            ST_DIV: begin
                dvd_reg <= {dvd_reg[dmsbt_pkg::TIME_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (trial_diff[dmsbt_pkg::CYC_W] == 1'b0)
                    rem_reg <= trial_diff[dmsbt_pkg::CYC_W-1:0];
                else
                    rem_reg <= trial[dmsbt_pkg::CYC_W-1:0];
            end
            ST_PHASE: begin
                kind_reg <= in_inhale ? dmsbt_pkg::PHASE_INHALE : dmsbt_pkg::PHASE_EXHALE;
                el_reg   <= el_sel;
                len_reg  <= len_sel;
                left_reg <= len_sel - el_sel;
            end
            default: ;
        endcase
    end

    assign m_tdata = {7'd0,
                      err_rec_reg, err_code_reg, err_src_reg, err_flag_reg,
                      left_reg, len_reg, el_reg, kind_reg,
                      session_reg, dmsbt_pkg::led_of_mode(mode_reg),
                      link_reg, mode_reg};

endmodule
